FILE: design/huffman_tree_byte_decoder_assert.svh
// Assertion macros shared by the decoder modules
`ifndef HUFFMAN_TREE_BYTE_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_BYTE_DECODER_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define HUFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hufd assertion failed");

// ante holds -> cons holds in the next cycle
`define HUFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hufd assertion failed");

`endif

FILE: design/hufd_pkg.sv
package hufd_pkg;

    localparam int WORD_W     = 9;
    localparam int ADDR_W     = 9;
    localparam int WORD_COUNT = 512;
    localparam int NODE_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 2;

    localparam int ROOT_NODE_DEF   = 254;
    localparam int LENGTH_BITS_DEF = 24;

    // tdata bits other than the length: index, value, data byte
    localparam int IN_FIXED_W = 2 * WORD_W + BYTE_W;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_emit;

endpackage

FILE: design/huffman_tree_byte_decoder.sv
// Channel  Dir  Fields (low bit up)                                  Accept
// s_axis   in   tdata: dict_index, dict_value, out_length, data_byte  tvalid & tready
//               tuser: cmd
// m_axis   out  tdata: out_byte; tlast: last                          tvalid & tready
//
// Load, start and unused commands are handled in their accept cycle.
// A data byte walks its bits from bit 0 up until bit 7 or the chunk's last byte,
// paced by the dictionary RAM's registered read: one tree node per cycle while not stalled.
// The walk stalls on a leaf while the output register holds an untaken word.
// Reset is synchronous, active low; the dictionary has no reset and no clearing pass.
module huffman_tree_byte_decoder #(
    parameter int ROOT_NODE   = hufd_pkg::ROOT_NODE_DEF,
    parameter int LENGTH_BITS = hufd_pkg::LENGTH_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // dict_index[8:0], dict_value[17:9], out_length, data_byte, zero pad
    input  logic [((hufd_pkg::IN_FIXED_W + LENGTH_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [hufd_pkg::CMD_W-1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_byte[7:0]
    output logic [hufd_pkg::BYTE_W-1:0] m_axis_tdata,
    output logic m_axis_tlast
);

    `include "huffman_tree_byte_decoder_assert.svh"

    localparam int VAL_LO = hufd_pkg::ADDR_W;
    localparam int LEN_LO = VAL_LO + hufd_pkg::WORD_W;
    localparam int BYT_LO = LEN_LO + LENGTH_BITS;

    hufd_pkg::t_wr_req             wr;
    hufd_pkg::t_rd_req             rd;
    hufd_pkg::t_emit               emit;
    logic [hufd_pkg::WORD_W-1:0]   rd_word;
    logic                          out_free;

    logic                          r_out_valid;
    logic [hufd_pkg::BYTE_W-1:0]   r_out_byte;
    logic                          r_out_last;

    assign out_free = !r_out_valid || m_axis_tready;

    hufd_dict_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_word (rd_word)
    );

    hufd_walker #(
        .ROOT_NODE   (ROOT_NODE),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_dict_index (s_axis_tdata[VAL_LO-1:0]),
        .i_dict_value (s_axis_tdata[LEN_LO-1:VAL_LO]),
        .i_out_length (s_axis_tdata[BYT_LO-1:LEN_LO]),
        .i_data_byte  (s_axis_tdata[BYT_LO+hufd_pkg::BYTE_W-1:BYT_LO]),
        .o_wr         (wr),
        .o_rd         (rd),
        .i_rd_word    (rd_word),
        .i_out_free   (out_free),
        .o_emit       (emit)
    );

    // output register parts the walk from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= emit.out_byte;
            r_out_last  <= emit.last;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

    `HUFD_ASSERT_IMP(a_emit_into_free, i_clk, i_rst_n, emit.valid, out_free)
    `HUFD_ASSERT_NXT(a_emit_shown, i_clk, i_rst_n, emit.valid, m_axis_tvalid)

endmodule

FILE: design/hufd_dict_ram.sv
module hufd_dict_ram (
    input  logic               i_clk,
    input  hufd_pkg::t_wr_req  i_wr,
    input  hufd_pkg::t_rd_req  i_rd,
    output logic [hufd_pkg::WORD_W-1:0] o_rd_word
);

    logic [hufd_pkg::WORD_W-1:0] r_mem [hufd_pkg::WORD_COUNT];
    logic [hufd_pkg::WORD_W-1:0] r_rd_word;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read data holds while no read is issued, so a stalled walk keeps its word
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_word <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_word = r_rd_word;

endmodule

FILE: design/hufd_walker.sv
module hufd_walker #(
    parameter int ROOT_NODE   = hufd_pkg::ROOT_NODE_DEF,
    parameter int LENGTH_BITS = hufd_pkg::LENGTH_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [hufd_pkg::CMD_W-1:0]    i_cmd,
    input  logic [hufd_pkg::ADDR_W-1:0]   i_dict_index,
    input  logic [hufd_pkg::WORD_W-1:0]   i_dict_value,
    input  logic [LENGTH_BITS-1:0]        i_out_length,
    input  logic [hufd_pkg::BYTE_W-1:0]   i_data_byte,
    output hufd_pkg::t_wr_req             o_wr,
    output hufd_pkg::t_rd_req             o_rd,
    input  logic [hufd_pkg::WORD_W-1:0]   i_rd_word,
    input  logic                          i_out_free,
    output hufd_pkg::t_emit               o_emit
);

    `include "huffman_tree_byte_decoder_assert.svh"

    typedef enum logic {S_IDLE, S_WALK} t_state;

    localparam logic [hufd_pkg::NODE_W-1:0] ROOT = hufd_pkg::NODE_W'(ROOT_NODE);
    localparam int IDX_W = $clog2(hufd_pkg::BYTE_W);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(hufd_pkg::BYTE_W - 1);

    t_state                        r_state;
    logic [hufd_pkg::BYTE_W-1:0]   r_shift;
    logic [IDX_W-1:0]              r_bit_idx;
    logic [hufd_pkg::NODE_W-1:0]   r_node;
    logic [LENGTH_BITS-1:0]        r_bytes_left;

    logic                          accept;
    logic                          is_leaf;
    logic                          advance;
    logic                          done;
    logic [LENGTH_BITS-1:0]        left_dec;
    logic [LENGTH_BITS-1:0]        step_left;
    logic [hufd_pkg::NODE_W-1:0]   step_node;
    logic                          data_go;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign data_go  = accept && (i_cmd == hufd_pkg::CMD_DATA) && (r_bytes_left != '0);

    // top bit of a child word set means an inner node
    assign is_leaf   = !i_rd_word[hufd_pkg::WORD_W-1];
    assign advance   = (r_state == S_WALK) && (!is_leaf || i_out_free);
    assign left_dec  = r_bytes_left - LENGTH_BITS'(1);
    assign step_left = is_leaf ? left_dec : r_bytes_left;
    assign step_node = is_leaf ? ROOT : i_rd_word[hufd_pkg::NODE_W-1:0];
    assign done      = (r_bit_idx == LAST_IDX) || (step_left == '0);

    always_comb begin
        o_wr.en   = accept && (i_cmd == hufd_pkg::CMD_LOAD);
        o_wr.addr = i_dict_index;
        o_wr.data = i_dict_value;

        o_rd.en   = 1'b0;
        o_rd.addr = {r_node, i_data_byte[0]};
        if (data_go) begin
            o_rd.en = 1'b1;
        end else if (advance && !done) begin
            o_rd.en   = 1'b1;
            o_rd.addr = {step_node, r_shift[1]};
        end

        o_emit.valid    = advance && is_leaf;
        o_emit.out_byte = i_rd_word[hufd_pkg::BYTE_W-1:0];
        o_emit.last     = (left_dec == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bit_idx    <= '0;
            r_node       <= ROOT;
            r_bytes_left <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_cmd == hufd_pkg::CMD_START)) begin
                        r_bytes_left <= i_out_length;
                        r_node       <= ROOT;
                    end
                    if (data_go) begin
                        r_shift   <= i_data_byte;
                        r_bit_idx <= '0;
                        r_state   <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (advance) begin
                        r_node       <= step_node;
                        r_bytes_left <= step_left;
                        r_shift      <= r_shift >> 1;
                        r_bit_idx    <= r_bit_idx + IDX_W'(1);
                        if (done) begin
                            r_bit_idx <= '0;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `HUFD_ASSERT_IMP(a_walk_has_length, i_clk, i_rst_n, r_state == S_WALK, r_bytes_left != '0)
    `HUFD_ASSERT_IMP(a_idle_idx_clear, i_clk, i_rst_n, r_state == S_IDLE, r_bit_idx == '0)
    `HUFD_ASSERT_NXT(a_data_starts_walk, i_clk, i_rst_n, data_go, r_state == S_WALK)
    `HUFD_ASSERT_IMP(a_read_not_on_load, i_clk, i_rst_n, o_wr.en, !o_rd.en)

endmodule

FILE: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMD_W      = hufd_pkg::CMD_W;
    localparam int ADDR_W     = hufd_pkg::ADDR_W;
    localparam int WORD_W     = hufd_pkg::WORD_W;
    localparam int NODE_W     = hufd_pkg::NODE_W;
    localparam int BYTE_W     = hufd_pkg::BYTE_W;
    localparam int WORD_COUNT = hufd_pkg::WORD_COUNT;

    localparam int LEN_W   = hufd_pkg::LENGTH_BITS_DEF;
    localparam int TDATA_W = ((hufd_pkg::IN_FIXED_W + LEN_W + 7) / 8) * 8;
    localparam int PAD_W   = TDATA_W - hufd_pkg::IN_FIXED_W - LEN_W;

    localparam logic [CMD_W-1:0]  CMD_SPARE = 2'd3;
    localparam logic [NODE_W-1:0] ROOT      = NODE_W'(hufd_pkg::ROOT_NODE_DEF);

    // first field in the lowest bits
    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  out_length;
        logic [WORD_W-1:0] dict_value;
        logic [ADDR_W-1:0] dict_index;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_decoded;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} t_rx_mode;

    // Tree walk predictor plus the queue of decoded bytes still owed by the block
    class decode_tracker;
        logic [WORD_W-1:0] tree_mem [WORD_COUNT];
        logic [NODE_W-1:0] walk_node;
        logic [LEN_W-1:0]  remaining;
        t_decoded          pending[$];
        int                faults;
        int                live_items;
        int                bytes_seen;

        function new();
            foreach (tree_mem[i]) tree_mem[i] = '0;
            walk_node = ROOT;
            remaining = '0;
        endfunction

        function void note_word(logic [CMD_W-1:0] cmd, t_in_word w);
            logic [WORD_W-1:0] child;
            case (cmd)
                hufd_pkg::CMD_LOAD: begin
                    tree_mem[w.dict_index] = w.dict_value;
                end
                hufd_pkg::CMD_START: begin
                    remaining = w.out_length;
                    walk_node = ROOT;
                    live_items++;
                end
                hufd_pkg::CMD_DATA: begin
                    if (remaining != 0) live_items++;
                    for (int b = 0; b < 8 && remaining != 0; b++) begin
                        child = tree_mem[{walk_node, w.data_byte[b]}];
                        if (!child[WORD_W-1]) begin
                            remaining--;
                            pending.push_back(t_decoded'{value: child[7:0],
                                                         last: remaining == 0});
                            walk_node = ROOT;
                        end else begin
                            walk_node = child[7:0];
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void flag(string what, int unsigned want, int unsigned got);
            faults++;
            if (faults <= 10)
                $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        endfunction

        function void check_byte(logic [BYTE_W-1:0] got, logic got_last);
            t_decoded exp_b;
            bytes_seen++;
            if (pending.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("stray output word %0h (tlast %0b) with nothing due", got, got_last);
                return;
            end
            exp_b = pending.pop_front();
            if (exp_b.value !== got) flag("byte", exp_b.value, got);
            if (exp_b.last !== got_last) flag("tlast", exp_b.last, got_last);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]    s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]   m_axis_tdata;
    logic                m_axis_tlast;

    decode_tracker tracker;
    bit            word_set [WORD_COUNT];
    int            burst_left = 0;
    int            chunk_count = 0;
    int            words_sent = 0;
    t_rx_mode      rx_mode = RX_OPEN;
    int            rx_span = 0;
    int unsigned   tick = 0;

    huffman_tree_byte_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // dict_index, dict_value, out_length, data_byte, pad
        .s_axis_tuser  (s_axis_tuser),   // cmd
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_byte
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver backpressure: switches between a few stall styles now and then
    always @(posedge i_clk) begin
        tick <= tick + 1;
        if (rx_span == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_span <= $urandom_range(16, 96);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= (tick[2:0] != 3'd5);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_byte(m_axis_tdata, m_axis_tlast);
    end

    initial begin
        #5_000_000;
        $display("timed out");
        $display("FAILURE");
        $finish;
    end

    // called at a rising edge; returns at the edge the word is taken, or after a random idle gap that follows it
    task automatic push_word(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] idx,
                             input logic [WORD_W-1:0] val, input logic [LEN_W-1:0] len,
                             input logic [BYTE_W-1:0] dbyte);
        t_in_word w;
        int       gap;
        w = '0;
        w.dict_index = idx;
        w.dict_value = val;
        w.out_length = len;
        w.data_byte  = dbyte;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_word(cmd, w);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic spare_word();
        push_word(CMD_SPARE, ADDR_W'($urandom), WORD_W'($urandom), LEN_W'($urandom),
                  BYTE_W'($urandom));
    endtask

    task automatic load_word(input logic [ADDR_W-1:0] idx, input logic [WORD_W-1:0] val);
        push_word(hufd_pkg::CMD_LOAD, idx, val, LEN_W'($urandom), BYTE_W'($urandom));
        word_set[idx] = 1'b1;
    endtask

    task automatic start_chunk(input logic [LEN_W-1:0] len);
        push_word(hufd_pkg::CMD_START, ADDR_W'($urandom), WORD_W'($urandom), len,
                  BYTE_W'($urandom));
        chunk_count++;
    endtask

    task automatic feed_byte(input logic [BYTE_W-1:0] dbyte);
        push_word(hufd_pkg::CMD_DATA, ADDR_W'($urandom), WORD_W'($urandom), LEN_W'($urandom),
                  dbyte);
    endtask

    // a leaf, or a link to a node whose two words are both loaded
    function automatic logic [WORD_W-1:0] safe_child();
        int n;
        if ($urandom_range(0, 1)) return WORD_W'($urandom_range(0, 255));
        repeat (8) begin
            n = $urandom_range(0, 255);
            if (word_set[2*n] && word_set[2*n+1]) return WORD_W'(9'h100 | n);
        end
        return WORD_W'($urandom_range(0, 255));
    endfunction

    // full binary tree from the root; a chain tree always grows the newest right branch
    task automatic build_tree(input int leaves, input bit chain);
        int        slots[$];
        bit [255:0] taken;
        int        pick;
        int        slot;
        int        node;
        taken = '0;
        taken[ROOT] = 1'b1;
        slots = '{2*ROOT, 2*ROOT+1};
        repeat (leaves - 2) begin
            pick = chain ? slots.size() - 1 : $urandom_range(0, slots.size() - 1);
            slot = slots[pick];
            slots.delete(pick);
            do node = $urandom_range(0, 255); while (taken[node]);
            taken[node] = 1'b1;
            load_word(ADDR_W'(slot), WORD_W'(9'h100 | node));
            slots.push_back(2*node);
            slots.push_back(2*node + 1);
        end
        foreach (slots[i]) load_word(ADDR_W'(slots[i]), WORD_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int fed;
        int roll;
        logic [LEN_W-1:0] len;

        tracker = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two-leaf root, then the awkward corners
        load_word(ADDR_W'(2*ROOT), 9'h000);
        load_word(ADDR_W'(2*ROOT + 1), 9'h0FF);
        spare_word();
        feed_byte(8'hA5);                 // no chunk open yet
        start_chunk('0);
        feed_byte(8'h5A);                 // zero length: nothing out
        start_chunk(LEN_W'(3));
        feed_byte(8'hFF);                 // tail bits dropped
        feed_byte(8'h00);                 // past the end
        start_chunk('1);
        feed_byte(8'h00);
        feed_byte(8'hA5);
        load_word(9'd511, 9'h001);
        load_word(9'd510, 9'h080);
        load_word(ADDR_W'(2*ROOT + 1), 9'h1FF);    // tree changed mid chunk
        feed_byte(8'hFF);
        load_word(9'd1, 9'h055);
        load_word(9'd0, 9'h100);          // node 0 loops on its left branch
        load_word(ADDR_W'(2*ROOT), 9'h100);
        feed_byte(8'h00);
        feed_byte(8'h02);
        start_chunk(LEN_W'(5));           // abandons the open chunk
        feed_byte(8'h6C);
        feed_byte(8'hFF);

        while (words_sent < 200) begin
            if (chunk_count < 8 || $urandom_range(0, 3) == 0)
                build_tree($urandom_range(2, 16), $urandom_range(0, 4) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 70)      len = LEN_W'($urandom_range(1, 24));
            else if (roll < 80) len = '0;
            else if (roll < 93) len = LEN_W'($urandom);
            else                len = '1;
            start_chunk(len);
            fed = 0;
            while (tracker.remaining != 0 && fed < 40) begin
                roll = $urandom_range(0, 99);
                if (roll < 86)      feed_byte(BYTE_W'($urandom));
                else if (roll < 93) load_word(ADDR_W'($urandom_range(0, 511)), safe_child());
                else if (roll < 97) spare_word();
                else                start_chunk(LEN_W'($urandom_range(1, 12)));
                fed++;
            end
            repeat ($urandom_range(0, 2)) feed_byte(BYTE_W'($urandom));
        end

        s_axis_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d input words (%0d live) over %0d chunks, random trees up to 16 leaves",
                 words_sent, tracker.live_items, chunk_count);
        $display("%0d decoded bytes checked, %0d faults", tracker.bytes_seen, tracker.faults);
        if (tracker.faults == 0 && tracker.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
